### hw/rtl/dbs_pkg.sv
// Shared types and constants for the bilinear elevation sampler.
`timescale 1ns / 1ps

package dbs_pkg;

  localparam int FRAC_W      = 24;
  localparam int POS_W       = FRAC_W + 1;
  localparam int DIM_W       = 9;
  localparam int BASE_W      = 2 * DIM_W;
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int SAMPLE_W    = 16;
  localparam int ELEV_W      = 24;
  localparam int WGT_W       = 2 * POS_W;
  localparam int PROD_W      = WGT_W + 1 + SAMPLE_W;
  localparam int ACC_W       = 64;
  localparam int ROUND_SHIFT = 2 * FRAC_W - 8;
  localparam int FIX_W       = 36;

  localparam logic [POS_W-1:0] FRAC_ONE = POS_W'(1) << FRAC_W;
  localparam logic signed [SAMPLE_W-1:0] NO_DATA_LIMIT = -16'sd9990;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SHIFT - 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_SOUTH = 2'd0,
    CFG_WEST  = 2'd1,
    CFG_COLS  = 2'd2,
    CFG_ROWS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    NB_00 = 2'd0,
    NB_01 = 2'd1,
    NB_10 = 2'd2,
    NB_11 = 2'd3
  } nbr_t;

  typedef struct packed {
    logic signed [7:0] south;
    logic signed [8:0] west;
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;
  } tile_cfg_t;

  typedef struct packed {
    logic              valid;
    nbr_t              nbr;
    logic [FRAC_W-1:0] tr;
    logic [FRAC_W-1:0] tc;
  } fetch_t;

endpackage

### hw/rtl/dbs_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module dbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/dbs_addr_gen.sv
// Request pipeline: coordinate mapping, neighbor indices and store port sequencing.
`timescale 1ns / 1ps

module dbs_addr_gen
  import dbs_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tile_cfg_t                  cfg,
  input  logic                       start,
  output logic                       busy,
  input  opcode_t                    in_opcode,
  input  logic [ADDR_W-1:0]          in_sample_index,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic signed [31:0]         in_query_latitude,
  input  logic signed [32:0]         in_query_longitude,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_addr,
  output logic [SAMPLE_W-1:0]        ram_wdata,
  output fetch_t                     fetch
);

  localparam logic [DIM_W-1:0] MAX_COLS_C =
    (MAX_COLUMNS > 511) ? DIM_W'(511) : DIM_W'(MAX_COLUMNS);
  localparam logic [DIM_W-1:0] MAX_ROWS_C =
    (MAX_ROWS > 511) ? DIM_W'(511) : DIM_W'(MAX_ROWS);
  localparam int RPOS_W = POS_W + DIM_W;
  localparam int IDX_W  = RPOS_W - FRAC_W;

  function automatic logic [POS_W-1:0] sat_unit(input logic signed [FIX_W-1:0] v);
    logic [POS_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(FIX_W'(FRAC_ONE))) begin
      res = FRAC_ONE;
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_idx(input logic [IDX_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v > IDX_W'(hi)) begin
      res = hi;
    end else begin
      res = v[DIM_W-1:0];
    end
    return res;
  endfunction

  logic [DIM_W-1:0] cols_eff, rows_eff, cols_m1, rows_m1;
  logic             stall, accept;
  nbr_t             cnt_r, cnt_nxt;

  // stage 1
  logic                       s1_valid_r;
  opcode_t                    s1_op_r;
  logic [ADDR_W-1:0]          s1_idx_r;
  logic [SAMPLE_W-1:0]        s1_val_r;
  logic signed [31:0]         s1_lat_r;
  logic signed [32:0]         s1_lon_r;
  // stage 2
  logic                       s2_valid_r;
  opcode_t                    s2_op_r;
  logic [ADDR_W-1:0]          s2_idx_r;
  logic [SAMPLE_W-1:0]        s2_val_r;
  logic [POS_W-1:0]           s2_dlat_r, s2_dlon_r;
  logic [POS_W-1:0]           dlat_nxt, dlon_nxt;
  logic signed [FIX_W-1:0]    lat_fix, lon_fix;
  // stage 3
  logic                       s3_valid_r;
  opcode_t                    s3_op_r;
  logic [ADDR_W-1:0]          s3_idx_r;
  logic [SAMPLE_W-1:0]        s3_val_r;
  logic [RPOS_W-1:0]          s3_rpos_r, s3_cpos_r;
  // stage 4
  logic                       s4_valid_r;
  opcode_t                    s4_op_r;
  logic [ADDR_W-1:0]          s4_idx_r;
  logic [SAMPLE_W-1:0]        s4_val_r;
  logic [DIM_W-1:0]           s4_r0_r, s4_r1_r, s4_c0_r, s4_c1_r;
  logic [FRAC_W-1:0]          s4_tr_r, s4_tc_r;
  logic [IDX_W-1:0]           r0_raw, c0_raw;
  // stage 5: store port
  logic                       s5_valid_r;
  opcode_t                    s5_op_r;
  logic [ADDR_W-1:0]          s5_idx_r;
  logic [SAMPLE_W-1:0]        s5_val_r;
  logic [BASE_W-1:0]          s5_base0_r, s5_base1_r;
  logic [DIM_W-1:0]           s5_c0_r, s5_c1_r;
  logic [FRAC_W-1:0]          s5_tr_r, s5_tc_r;
  logic                       s5_query, row_far, col_far;
  logic [BASE_W-1:0]          row_base;
  logic [DIM_W-1:0]           col_sel;

  always_comb begin
    cols_eff = (cfg.cols < DIM_W'(2)) ? DIM_W'(2) :
               ((cfg.cols > MAX_COLS_C) ? MAX_COLS_C : cfg.cols);
    rows_eff = (cfg.rows < DIM_W'(2)) ? DIM_W'(2) :
               ((cfg.rows > MAX_ROWS_C) ? MAX_ROWS_C : cfg.rows);
    cols_m1  = cols_eff - DIM_W'(1);
    rows_m1  = rows_eff - DIM_W'(1);
  end

  assign s5_query = s5_valid_r && (s5_op_r == OP_QUERY);
  assign stall    = s5_query && (cnt_r != NB_11);
  assign busy     = stall;
  assign accept   = start && !busy;
  assign cnt_nxt  = s5_query ? nbr_t'(cnt_r + 2'd1) : NB_00;

  // hold every stage while a query is still fetching neighbors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      cnt_r      <= NB_00;
    end else begin
      cnt_r <= cnt_nxt;
      if (!stall) begin
        s1_valid_r <= accept;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
        s4_valid_r <= s3_valid_r;
        s5_valid_r <= s4_valid_r;
      end
    end
  end

  always_comb begin
    lat_fix  = (FIX_W'(cfg.south) + FIX_W'(1)) <<< FRAC_W;
    lat_fix  = lat_fix - FIX_W'(s1_lat_r);
    lon_fix  = FIX_W'(s1_lon_r) - (FIX_W'(cfg.west) <<< FRAC_W);
    dlat_nxt = sat_unit(lat_fix);
    dlon_nxt = sat_unit(lon_fix);
    r0_raw   = s3_rpos_r[RPOS_W-1:FRAC_W];
    c0_raw   = s3_cpos_r[RPOS_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_opcode;
      s1_idx_r <= in_sample_index;
      s1_val_r <= in_sample_value;
      s1_lat_r <= in_query_latitude;
      s1_lon_r <= in_query_longitude;
    end
    if (!stall) begin
      s2_op_r    <= s1_op_r;
      s2_idx_r   <= s1_idx_r;
      s2_val_r   <= s1_val_r;
      s2_dlat_r  <= dlat_nxt;
      s2_dlon_r  <= dlon_nxt;

      s3_op_r    <= s2_op_r;
      s3_idx_r   <= s2_idx_r;
      s3_val_r   <= s2_val_r;
      s3_rpos_r  <= s2_dlat_r * rows_m1;
      s3_cpos_r  <= s2_dlon_r * cols_m1;

      s4_op_r    <= s3_op_r;
      s4_idx_r   <= s3_idx_r;
      s4_val_r   <= s3_val_r;
      s4_r0_r    <= clamp_idx(r0_raw, rows_m1);
      s4_r1_r    <= clamp_idx(r0_raw + IDX_W'(1), rows_m1);
      s4_c0_r    <= clamp_idx(c0_raw, cols_m1);
      s4_c1_r    <= clamp_idx(c0_raw + IDX_W'(1), cols_m1);
      s4_tr_r    <= s3_rpos_r[FRAC_W-1:0];
      s4_tc_r    <= s3_cpos_r[FRAC_W-1:0];

      s5_op_r    <= s4_op_r;
      s5_idx_r   <= s4_idx_r;
      s5_val_r   <= s4_val_r;
      s5_base0_r <= s4_r0_r * cols_eff;
      s5_base1_r <= s4_r1_r * cols_eff;
      s5_c0_r    <= s4_c0_r;
      s5_c1_r    <= s4_c1_r;
      s5_tr_r    <= s4_tr_r;
      s5_tc_r    <= s4_tc_r;
    end
  end

  always_comb begin
    row_far   = (cnt_r == NB_10) || (cnt_r == NB_11);
    col_far   = (cnt_r == NB_01) || (cnt_r == NB_11);
    row_base  = row_far ? s5_base1_r : s5_base0_r;
    col_sel   = col_far ? s5_c1_r : s5_c0_r;
    ram_we    = s5_valid_r && (s5_op_r == OP_WRITE);
    ram_wdata = s5_val_r;
    if (ram_we) begin
      ram_addr = s5_idx_r;
    end else begin
      ram_addr = ADDR_W'(row_base + BASE_W'(col_sel));
    end
    fetch.valid = s5_query;
    fetch.nbr   = cnt_r;
    fetch.tr    = s5_tr_r;
    fetch.tc    = s5_tc_r;
  end

endmodule

### hw/rtl/dbs_blend.sv
// Bilinear weighting and accumulation of the four fetched neighbors.
`timescale 1ns / 1ps

module dbs_blend
  import dbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  fetch_t                   fetch,
  input  logic [SAMPLE_W-1:0]      ram_rdata,
  output logic                     out_valid,
  output logic signed [ELEV_W-1:0] out_elevation
);

  logic                     row_far, col_far;
  logic [POS_W-1:0]         wr, wc;
  logic [WGT_W-1:0]         w_nxt;

  logic                     v1_r;
  nbr_t                     nbr1_r;
  logic [WGT_W-1:0]         w_r;

  logic signed [SAMPLE_W-1:0] sample, elev;
  logic signed [PROD_W-1:0] prod_nxt;

  logic                     v2_r;
  nbr_t                     nbr2_r;
  logic signed [ACC_W-1:0]  prod_r;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     out_valid_r;
  logic signed [ELEV_W-1:0] out_elev_r;

  always_comb begin
    row_far = (fetch.nbr == NB_10) || (fetch.nbr == NB_11);
    col_far = (fetch.nbr == NB_01) || (fetch.nbr == NB_11);
    wr      = row_far ? {1'b0, fetch.tr} : FRAC_ONE - {1'b0, fetch.tr};
    wc      = col_far ? {1'b0, fetch.tc} : FRAC_ONE - {1'b0, fetch.tc};
    w_nxt   = wr * wc;
  end

  // drop no-data neighbors to zero
  always_comb begin
    sample   = $signed(ram_rdata);
    elev     = (sample < NO_DATA_LIMIT) ? '0 : sample;
    prod_nxt = $signed({1'b0, w_r}) * elev;
    acc_nxt  = ((nbr2_r == NB_00) ? ROUND_HALF : acc_r) + prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= fetch.valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r && (nbr2_r == NB_11);
    end
  end

  always_ff @(posedge clk) begin
    nbr1_r <= fetch.nbr;
    w_r    <= w_nxt;
    nbr2_r <= nbr1_r;
    prod_r <= prod_nxt[ACC_W-1:0];
    if (v2_r) begin
      acc_r      <= acc_nxt;
      out_elev_r <= acc_nxt[ACC_W-1 -: ELEV_W];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_elevation = out_elev_r;

endmodule

### hw/rtl/dem_bilinear_sampler_top.sv
// Top level of the bilinear elevation sampler: configuration registers and store.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A write request stores
// one sample with a single write on the store port; a query reads the store once
// per neighbor, four reads in turn, and busy is high while it reads all but its
// last neighbor, which holds every stage, so requests behind it wait. Writes go
// one per cycle while no query holds the pipeline. The result of a query shows on
// out_valid and out_elevation for one cycle; it cannot be held off. Requests
// reach the store in order, so a query sees every write taken before it. The
// store is not cleared after reset: every sample a query touches must first be
// written. Write configuration only while no request is in flight.

module dem_bilinear_sampler_top
  import dbs_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_opcode,
  input  logic [15:0]                in_sample_index,
  input  logic signed [15:0]         in_sample_value,
  input  logic signed [31:0]         in_query_latitude,
  input  logic signed [32:0]         in_query_longitude,
  output logic                       out_valid,
  output logic signed [23:0]         out_elevation,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [8:0]                 cfg_data
);

  tile_cfg_t           cfg_r;
  logic                cfg_we;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  fetch_t              fetch;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.south <= '0;
      cfg_r.west  <= '0;
      cfg_r.cols  <= DIM_W'(256);
      cfg_r.rows  <= DIM_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SOUTH: cfg_r.south <= $signed(cfg_data[7:0]);
        CFG_WEST:  cfg_r.west  <= $signed(cfg_data);
        CFG_COLS:  cfg_r.cols  <= cfg_data;
        CFG_ROWS:  cfg_r.rows  <= cfg_data;
        default:   cfg_r       <= cfg_r;
      endcase
    end
  end

  dbs_addr_gen #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_addr_gen (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .start             (start),
    .busy              (busy),
    .in_opcode         (opcode_t'(in_opcode)),
    .in_sample_index   (in_sample_index),
    .in_sample_value   (in_sample_value),
    .in_query_latitude (in_query_latitude),
    .in_query_longitude(in_query_longitude),
    .ram_we            (ram_we),
    .ram_addr          (ram_addr),
    .ram_wdata         (ram_wdata),
    .fetch             (fetch)
  );

  dbs_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  dbs_blend u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .fetch        (fetch),
    .ram_rdata    (ram_rdata),
    .out_valid    (out_valid),
    .out_elevation(out_elevation)
  );

`ifndef ASSERT_OFF
  a_busy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) && $past(busy, 2) |=> !busy)
    else $error("busy held longer than one query fetch");

  a_result_after_last_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(fetch.valid && (fetch.nbr == NB_11), 3))
    else $error("result without a completed neighbor fetch");

  a_no_write_during_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !fetch.valid)
    else $error("store write collides with a neighbor read");
`endif

endmodule

### tb/sv/dem_bilinear_sampler_top_test.sv
// Self-checking testbench for the bilinear elevation sampler: sample loads, queries, tile setup.
`timescale 1ns / 1ps

localparam longint FIX_ONE    = 64'sd16777216;
localparam longint GRID_LIMIT = 256;
localparam longint NO_DATA    = -9990;

class dem_tile_tracker;
  logic [15:0]        tile_samples [0:65535];
  bit                 sample_written [0:65535];
  logic [23:0]        pending_elevations [$];
  logic signed [7:0]  south_deg;
  logic signed [8:0]  west_deg;
  logic [8:0]         grid_cols;
  logic [8:0]         grid_rows;
  logic [15:0]        corner_addr [4];
  longint             frac_row;
  longint             frac_col;
  int                 errors;

  function new();
    south_deg = 8'sd0;
    west_deg  = 9'sd0;
    grid_cols = 9'd256;
    grid_rows = 9'd256;
    errors    = 0;
  endfunction

  function void set_reg(dbs_pkg::cfg_reg_t idx, logic [8:0] data);
    case (idx)
      dbs_pkg::CFG_SOUTH: south_deg = data[7:0];
      dbs_pkg::CFG_WEST:  west_deg  = data;
      dbs_pkg::CFG_COLS:  grid_cols = data;
      dbs_pkg::CFG_ROWS:  grid_rows = data;
      default: ;
    endcase
  endfunction

  function longint clamp_dim(logic [8:0] v);
    if (v < 2) return 2;
    if (v > GRID_LIMIT) return GRID_LIMIT;
    return longint'(v);
  endfunction

  function longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > FIX_ONE) return FIX_ONE;
    return v;
  endfunction

  function void locate(logic signed [31:0] lat, logic signed [32:0] lon);
    longint n_cols, n_rows, dlat, dlon, rpos, cpos, r0, r1, c0, c1;
    n_cols = clamp_dim(grid_cols);
    n_rows = clamp_dim(grid_rows);
    dlat = clamp_unit((longint'(south_deg) + 1) * FIX_ONE - longint'(lat));
    dlon = clamp_unit(longint'(lon) - longint'(west_deg) * FIX_ONE);
    rpos = dlat * (n_rows - 1);
    cpos = dlon * (n_cols - 1);
    r0 = rpos >>> 24;
    c0 = cpos >>> 24;
    frac_row = rpos & 64'hFFFFFF;
    frac_col = cpos & 64'hFFFFFF;
    r1 = r0 + 1;
    c1 = c0 + 1;
    if (r0 > n_rows - 1) r0 = n_rows - 1;
    if (c0 > n_cols - 1) c0 = n_cols - 1;
    if (r1 > n_rows - 1) r1 = n_rows - 1;
    if (c1 > n_cols - 1) c1 = n_cols - 1;
    corner_addr[dbs_pkg::NB_00] = 16'(r0 * n_cols + c0);
    corner_addr[dbs_pkg::NB_01] = 16'(r0 * n_cols + c1);
    corner_addr[dbs_pkg::NB_10] = 16'(r1 * n_cols + c0);
    corner_addr[dbs_pkg::NB_11] = 16'(r1 * n_cols + c1);
  endfunction

  function longint level(logic [15:0] addr);
    longint s;
    s = longint'($signed(tile_samples[addr]));
    return (s < NO_DATA) ? 0 : s;
  endfunction

  function logic [23:0] blend(logic signed [31:0] lat, logic signed [32:0] lon);
    longint e00, e01, e10, e11, acc;
    locate(lat, lon);
    e00 = level(corner_addr[dbs_pkg::NB_00]);
    e01 = level(corner_addr[dbs_pkg::NB_01]);
    e10 = level(corner_addr[dbs_pkg::NB_10]);
    e11 = level(corner_addr[dbs_pkg::NB_11]);
    acc = (FIX_ONE - frac_row) * (FIX_ONE - frac_col) * e00
        + (FIX_ONE - frac_row) * frac_col * e01
        + frac_row * (FIX_ONE - frac_col) * e10
        + frac_row * frac_col * e11
        + (64'sd1 <<< 39);
    return 24'(acc >>> 40);
  endfunction

  function void note_request(dbs_pkg::opcode_t op, logic [15:0] idx, logic signed [15:0] val,
                             logic signed [31:0] lat, logic signed [32:0] lon);
    if (op == dbs_pkg::OP_WRITE) begin
      tile_samples[idx]   = val;
      sample_written[idx] = 1'b1;
    end else begin
      pending_elevations.push_back(blend(lat, lon));
    end
  endfunction

  function void check_elevation(logic signed [23:0] actual);
    logic signed [23:0] predicted;
    if (pending_elevations.size() == 0) begin
      $error("elevation: no result expected, actual %0d", actual);
      errors++;
    end else begin
      predicted = pending_elevations.pop_front();
      if (predicted !== actual) begin
        $error("elevation: expected %0d, actual %0d", predicted, actual);
        errors++;
      end
    end
  endfunction
endclass

module dem_bilinear_sampler_top_test;
  import dbs_pkg::*;

  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          PHASE_ITEMS  = 152;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_opcode;
  logic [15:0]        in_sample_index;
  logic signed [15:0] in_sample_value;
  logic signed [31:0] in_query_latitude;
  logic signed [32:0] in_query_longitude;
  logic               out_valid;
  logic signed [23:0] out_elevation;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [8:0]         cfg_data;

  dem_tile_tracker tracker;
  int unsigned     cycle_count = 0;
  int unsigned     sent_count = 0;
  bit              steady;

  dem_bilinear_sampler_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_sample_index   (in_sample_index),
    .in_sample_value   (in_sample_value),
    .in_query_latitude (in_query_latitude),
    .in_query_longitude(in_query_longitude),
    .out_valid         (out_valid),
    .out_elevation     (out_elevation),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_elevation(out_elevation);
  end

  task automatic idle_gap();
    int roll;
    int n;
    roll = $urandom_range(0, 9);
    n = 0;
    if (!steady) begin
      if (roll >= 9) n = $urandom_range(5, 24);
      else if (roll >= 6) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(opcode_t op, logic [15:0] idx, logic signed [15:0] val,
                       logic signed [31:0] lat, logic signed [32:0] lon);
    start              <= 1'b1;
    in_opcode          <= op;
    in_sample_index    <= idx;
    in_sample_value    <= val;
    in_query_latitude  <= lat;
    in_query_longitude <= lon;
    do @(posedge clk); while (busy);
    tracker.note_request(op, idx, val, lat, lon);
    sent_count++;
    idle_gap();
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return -16'sd9990;
      1: return 16'(-9991 - int'($urandom_range(0, 22777)));
      2: return 16'sh7FFF;
      3: return 16'sh8000;
      4: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 9000)) - 1000);
    endcase
  endfunction

  task automatic write_sample(logic [15:0] idx, logic signed [15:0] val);
    issue(OP_WRITE, idx, val, 32'($urandom), 33'({$urandom, $urandom}));
  endtask

  // load any corner the query touches that was never written; optionally refresh the rest
  task automatic query(logic signed [31:0] lat, logic signed [32:0] lon, bit refresh);
    logic [15:0] addr;
    tracker.locate(lat, lon);
    for (int k = 0; k < 4; k++) begin
      addr = tracker.corner_addr[k];
      if (!tracker.sample_written[addr] || (refresh && $urandom_range(0, 3) == 0))
        write_sample(addr, pick_sample());
    end
    issue(OP_QUERY, 16'($urandom), 16'($urandom), lat, lon);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_elevations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tile(logic [8:0] south, logic [8:0] west, logic [8:0] cols,
                          logic [8:0] rows);
    cfg_write(CFG_SOUTH, south);
    cfg_write(CFG_WEST, west);
    cfg_write(CFG_COLS, cols);
    cfg_write(CFG_ROWS, rows);
  endtask

  function automatic logic [8:0] pick_dim();
    case ($urandom_range(0, 3))
      0: return 9'($urandom_range(0, 4));
      1: return 9'($urandom_range(250, 260));
      2: return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic random_query();
    longint base_lat;
    longint base_lon;
    longint lat;
    longint lon;
    int     mode;
    base_lat = longint'(tracker.south_deg) * FIX_ONE;
    base_lon = longint'(tracker.west_deg) * FIX_ONE;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      lat = base_lat + $urandom_range(0, 16777216);
      lon = base_lon + $urandom_range(0, 16777216);
    end else if (mode == 7) begin
      lat = base_lat + ($urandom_range(0, 1) ? FIX_ONE : 0) + $urandom_range(0, 2) - 1;
      lon = base_lon + ($urandom_range(0, 1) ? FIX_ONE : 0) + $urandom_range(0, 2) - 1;
    end else if (mode == 8) begin
      lat = base_lat - FIX_ONE / 4 + $urandom_range(0, 25165824);
      lon = base_lon - FIX_ONE / 4 + $urandom_range(0, 25165824);
    end else begin
      lat = longint'($urandom);
      lon = longint'({$urandom, $urandom});
    end
    query(32'(lat), 33'(lon), 1'b1);
  endtask

  // send requests until this phase has taken about count of them
  task automatic run_random(int count);
    int unsigned stop_at;
    int          i;
    stop_at = sent_count + count;
    i = 0;
    while (sent_count < stop_at) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 2) write_sample(16'($urandom), pick_sample());
      else random_query();
      i++;
    end
  endtask

  task automatic run_directed();
    write_sample(16'h0000, 16'sh7FFF);
    write_sample(16'hFFFF, 16'sh8000);
    write_sample(16'h0001, -16'sd9990);
    write_sample(16'h0100, -16'sd9991);
    write_sample(16'h0101, 16'sh8000);
    query(32'sd16777216, 33'sd0, 1'b0);
    query(32'sd0, 33'sd16777216, 1'b0);
    query(32'sd16744448, 33'sd32768, 1'b0);
    query(32'sd8388608, 33'sd8388608, 1'b0);
    query(32'sd16777216, 33'sd16777216, 1'b0);
    query(32'sd0, 33'sd0, 1'b0);
    query(32'sh7FFFFFFF, 33'h0FFFFFFFF, 1'b0);
    query(32'sh80000000, 33'h100000000, 1'b0);
    query(32'sd20000000, -33'sd5, 1'b0);
    query(-32'sd3, 33'sd17000000, 1'b0);
  endtask

  initial begin
    tracker = new();
    steady  = 1'b0;
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_opcode          <= OP_WRITE;
    in_sample_index    <= '0;
    in_sample_value    <= '0;
    in_query_latitude  <= '0;
    in_query_longitude <= '0;
    cfg_valid          <= 1'b0;
    cfg_index          <= CFG_SOUTH;
    cfg_data           <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      case (phase)
        0: set_tile({1'($urandom), 8'h80}, 9'h100, 9'd2, 9'd2);
        1: set_tile({1'($urandom), 8'h7F}, 9'h0FF, 9'd256, 9'd256);
        2: set_tile({1'($urandom), 8'(-90)}, 9'(-180), 9'd0, 9'd1);
        3: set_tile({1'($urandom), 8'd89}, 9'd179, 9'd511, 9'd257);
        default: set_tile(9'($urandom), 9'($urandom), pick_dim(), pick_dim());
      endcase
      run_random(PHASE_ITEMS);
    end
    drain();

    if (tracker.pending_elevations.size() != 0) begin
      $error("elevation: %0d expected results never arrived",
             tracker.pending_elevations.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dbs_pkg.sv
hw/rtl/dbs_ram.sv
hw/rtl/dbs_addr_gen.sv
hw/rtl/dbs_blend.sv
hw/rtl/dem_bilinear_sampler_top.sv
tb/sv/dem_bilinear_sampler_top_test.sv
